### design/ptsb_pkg.sv
// Shared types and codes for the periodic timer slot bank.
package ptsb_pkg;

    typedef enum logic [2:0] {
        ACT_ADD_SEC = 3'd0,
        ACT_ADD_MIN = 3'd1,
        ACT_REMOVE  = 3'd2,
        ACT_TICK    = 3'd3,
        ACT_QUERY   = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_REARMED   = 3'd1,
        ST_WRONGKIND = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOTARMED  = 3'd4,
        ST_ARMED     = 3'd5,
        ST_UNARMED   = 3'd6,
        ST_TICK      = 3'd7
    } status_t;

    localparam logic KIND_SEC = 1'b0;
    localparam logic KIND_MIN = 1'b1;

    typedef struct packed {
        logic arm;
        logic disarm;
        logic kind;
        logic tick;
        logic min_tick;
        logic shift;
    } cell_cmd_t;

    typedef struct packed {
        logic fire;
        logic kind;
    } fire_link_t;

    typedef struct packed {
        logic armed;
        logic kind;
    } cell_stat_t;

endpackage

### design/ptsb_cell.sv
// One timer slot: arm state, reload and remaining count, and a fire flag stage of the scan chain.
module ptsb_cell
    import ptsb_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cell_cmd_t              cmd,
    input  logic                   sel,
    input  logic [COUNT_WIDTH-1:0] period,
    input  fire_link_t             link_in,
    output fire_link_t             link_out,
    output cell_stat_t             stat
);

    logic                   armed_reg, armed_next;
    logic                   kind_reg, kind_next;
    logic [COUNT_WIDTH-1:0] reload_reg, reload_next;
    logic [COUNT_WIDTH-1:0] remain_reg, remain_next;
    fire_link_t             link_reg, link_next;
    logic [COUNT_WIDTH-1:0] remain_dec;
    logic                   counts;

    assign remain_dec = remain_reg - COUNT_WIDTH'(1);
    assign counts     = armed_reg && (kind_reg == KIND_SEC || cmd.min_tick);

    always_comb begin
        armed_next  = armed_reg;
        kind_next   = kind_reg;
        reload_next = reload_reg;
        remain_next = remain_reg;
        link_next   = link_reg;
        priority if (cmd.arm && sel) begin
            armed_next  = 1'b1;
            kind_next   = cmd.kind;
            reload_next = period;
            remain_next = period;
        end else if (cmd.disarm && sel) begin
            armed_next = 1'b0;
        end else if (cmd.tick) begin
            link_next.kind = kind_reg;
            link_next.fire = 1'b0;
            if (counts) begin
                if (remain_dec == '0) begin
                    remain_next    = reload_reg;
                    link_next.fire = 1'b1;
                end else begin
                    remain_next = remain_dec;
                end
            end
        end else if (cmd.shift) begin
            link_next = link_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= 1'b0;
            kind_reg  <= 1'b0;
            link_reg  <= '0;
        end else begin
            armed_reg <= armed_next;
            kind_reg  <= kind_next;
            link_reg  <= link_next;
        end
        reload_reg <= reload_next;
        remain_reg <= remain_next;
    end

    assign link_out   = link_reg;
    assign stat.armed = armed_reg;
    assign stat.kind  = kind_reg;

endmodule

### design/periodic_timer_slot_bank_top.sv
// Top level of the periodic timer slot bank: command decode, scan control and result register.
//
//   port group  dir  handshake          payload
//   s_*         in   s_valid/s_ready    action, slot, period, minute_now
//   m_*         out  m_valid/m_ready    status, fired, fired_slot, fired_kind, last
//
// Add, remove and query each give one item.
// A tick first counts down all slots at once, then shifts the fire flags down the row of cells
// to the head slot by slot, then gives the final item.
// The scan holds while an item waits in the result register and the next one is due.
// Reset clears arm state, kinds, fire flags and minute tracking; counts are written on arm.
module periodic_timer_slot_bank_top
    import ptsb_pkg::*;
#(
    parameter int NUM_SLOTS   = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [3:0]  s_slot,
    input  logic [15:0] s_period,
    input  logic [5:0]  s_minute_now,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic        m_fired,
    output logic [3:0]  m_fired_slot,
    output logic        m_fired_kind,
    output logic        m_last
);

    localparam int IDXW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NUM_SLOTS - 1);

    typedef enum logic [2:0] {
        FSM_IDLE  = 3'b001,
        FSM_SCAN  = 3'b010,
        FSM_FLUSH = 3'b100
    } fsm_t;

    fsm_t            state_reg, state_next;
    logic [IDXW-1:0] idx_reg, idx_next;
    logic            pend_reg, pend_next;
    logic [3:0]      pend_slot_reg, pend_slot_next;
    logic            pend_kind_reg, pend_kind_next;
    logic            min_seen_reg, min_seen_next;
    logic [5:0]      last_min_reg, last_min_next;

    logic            m_valid_reg, m_valid_next;
    status_t         m_status_reg, m_status_next;
    logic            m_fired_reg, m_fired_next;
    logic [3:0]      m_fired_slot_reg, m_fired_slot_next;
    logic            m_fired_kind_reg, m_fired_kind_next;
    logic            m_last_reg, m_last_next;

    cell_cmd_t              cmd;
    logic [NUM_SLOTS-1:0]   sel;
    cell_stat_t             stat [NUM_SLOTS];
    fire_link_t             link [NUM_SLOTS+1];
    logic [COUNT_WIDTH-1:0] period_w;
    logic                   slot_valid;
    cell_stat_t             addr_stat;
    logic                   out_free;
    logic                   ready_int;
    logic                   need_emit;

    assign period_w   = COUNT_WIDTH'(s_period);
    assign slot_valid = {28'd0, s_slot} < NUM_SLOTS;
    assign link[NUM_SLOTS] = '0;

    always_comb begin
        sel       = '0;
        addr_stat = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_valid && {28'd0, s_slot} == i) begin
                sel[i]    = 1'b1;
                addr_stat = stat[i];
            end
        end
    end

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        ptsb_cell #(
            .COUNT_WIDTH(COUNT_WIDTH)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd),
            .sel     (sel[g]),
            .period  (period_w),
            .link_in (link[g+1]),
            .link_out(link[g]),
            .stat    (stat[g])
        );
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign need_emit = link[0].fire && pend_reg;

    always_comb begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        pend_next         = pend_reg;
        pend_slot_next    = pend_slot_reg;
        pend_kind_next    = pend_kind_reg;
        min_seen_next     = min_seen_reg;
        last_min_next     = last_min_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_status_next     = m_status_reg;
        m_fired_next      = m_fired_reg;
        m_fired_slot_next = m_fired_slot_reg;
        m_fired_kind_next = m_fired_kind_reg;
        m_last_next       = m_last_reg;
        cmd               = '0;
        ready_int         = 1'b0;

        unique case (state_reg)
            FSM_IDLE: begin
                ready_int = out_free;
                if (s_valid && out_free) begin
                    m_fired_next      = 1'b0;
                    m_fired_slot_next = '0;
                    m_fired_kind_next = 1'b0;
                    m_last_next       = 1'b1;
                    unique case (action_t'(s_action))
                        ACT_ADD_SEC, ACT_ADD_MIN: begin
                            m_valid_next = 1'b1;
                            cmd.kind     = s_action[0];
                            if (!slot_valid) begin
                                m_status_next = ST_WRONGKIND;
                            end else if (!addr_stat.armed) begin
                                cmd.arm       = 1'b1;
                                m_status_next = ST_ADDED;
                            end else if (addr_stat.kind == s_action[0]) begin
                                cmd.arm       = 1'b1;
                                m_status_next = ST_REARMED;
                            end else begin
                                m_status_next = ST_WRONGKIND;
                            end
                        end
                        ACT_REMOVE: begin
                            m_valid_next = 1'b1;
                            if (addr_stat.armed) begin
                                cmd.disarm    = 1'b1;
                                m_status_next = ST_REMOVED;
                            end else begin
                                m_status_next = ST_NOTARMED;
                            end
                        end
                        ACT_QUERY: begin
                            m_valid_next  = 1'b1;
                            m_status_next = addr_stat.armed ? ST_ARMED : ST_UNARMED;
                        end
                        ACT_TICK: begin
                            cmd.tick      = 1'b1;
                            cmd.min_tick  = min_seen_reg && (last_min_reg != s_minute_now);
                            min_seen_next = 1'b1;
                            last_min_next = s_minute_now;
                            idx_next      = '0;
                            pend_next     = 1'b0;
                            state_next    = FSM_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            FSM_SCAN: begin
                if (!(need_emit && !out_free)) begin
                    cmd.shift = 1'b1;
                    if (link[0].fire) begin
                        if (pend_reg) begin
                            m_valid_next      = 1'b1;
                            m_status_next     = ST_TICK;
                            m_fired_next      = 1'b1;
                            m_fired_slot_next = pend_slot_reg;
                            m_fired_kind_next = pend_kind_reg;
                            m_last_next       = 1'b0;
                        end
                        pend_next      = 1'b1;
                        pend_slot_next = 4'(idx_reg);
                        pend_kind_next = link[0].kind;
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_next = FSM_FLUSH;
                    end else begin
                        idx_next = idx_reg + IDXW'(1);
                    end
                end
            end
            FSM_FLUSH: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_status_next     = ST_TICK;
                    m_fired_next      = pend_reg;
                    m_fired_slot_next = pend_reg ? pend_slot_reg : 4'd0;
                    m_fired_kind_next = pend_reg && pend_kind_reg;
                    m_last_next       = 1'b1;
                    state_next        = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_IDLE;
            pend_reg     <= 1'b0;
            min_seen_reg <= 1'b0;
            last_min_reg <= '0;
            m_valid_reg  <= 1'b0;
            idx_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            min_seen_reg <= min_seen_next;
            last_min_reg <= last_min_next;
            m_valid_reg  <= m_valid_next;
            idx_reg      <= idx_next;
        end
        pend_slot_reg    <= pend_slot_next;
        pend_kind_reg    <= pend_kind_next;
        m_status_reg     <= m_status_next;
        m_fired_reg      <= m_fired_next;
        m_fired_slot_reg <= m_fired_slot_next;
        m_fired_kind_reg <= m_fired_kind_next;
        m_last_reg       <= m_last_next;
    end

    assign s_ready      = ready_int;
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_fired      = m_fired_reg;
    assign m_fired_slot = m_fired_slot_reg;
    assign m_fired_kind = m_fired_kind_reg;
    assign m_last       = m_last_reg;

endmodule

### verif/tb_top.sv
// Self-checking testbench for the periodic timer slot bank: directed table, random items, stalls.
module tb_top;
    import ptsb_pkg::*;

    localparam int NUM_SLOTS   = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_PER_PHASE = 140;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [2:0] ACT_RSVD_5 = 3'd5;
    localparam logic [2:0] ACT_RSVD_6 = 3'd6;
    localparam logic [2:0] ACT_RSVD_7 = 3'd7;

    typedef struct packed {
        status_t    status;
        logic       fired;
        logic [3:0] fired_slot;
        logic       fired_kind;
        logic       last;
    } timer_result_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  slot;
        logic [15:0] period;
        logic [5:0]  minute;
        logic        pinned;
        status_t     pin_status;
    } directed_row_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_action = ACT_QUERY;
    logic [3:0]  s_slot = '0;
    logic [15:0] s_period = '0;
    logic [5:0]  s_minute_now = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic        m_fired;
    logic [3:0]  m_fired_slot;
    logic        m_fired_kind;
    logic        m_last;

    bit          bank_armed [NUM_SLOTS];
    bit          bank_kind [NUM_SLOTS];
    bit [15:0]   bank_reload [NUM_SLOTS];
    bit [15:0]   bank_count [NUM_SLOTS];
    bit          minute_valid;
    bit [5:0]    prev_minute;

    timer_result_t step_results[$];
    timer_result_t due_results[$];
    timer_result_t head_result;

    int unsigned error_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_request;
    int          hold_left;
    logic [5:0]  cur_minute;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ACT_QUERY,   4'd0,  16'h0000, 6'd0,  1'b1, ST_UNARMED},
        '{ACT_QUERY,   4'd15, 16'hFFFF, 6'd63, 1'b1, ST_UNARMED},
        '{ACT_REMOVE,  4'd7,  16'h0000, 6'd0,  1'b1, ST_NOTARMED},
        '{ACT_TICK,    4'd0,  16'h0000, 6'd0,  1'b1, ST_TICK},
        '{ACT_ADD_SEC, 4'd0,  16'd1,    6'd0,  1'b1, ST_ADDED},
        '{ACT_ADD_MIN, 4'd15, 16'd1,    6'd0,  1'b1, ST_ADDED},
        '{ACT_ADD_MIN, 4'd0,  16'd5,    6'd0,  1'b1, ST_WRONGKIND},
        '{ACT_ADD_SEC, 4'd15, 16'd5,    6'd0,  1'b1, ST_WRONGKIND},
        '{ACT_ADD_SEC, 4'd0,  16'd1,    6'd0,  1'b1, ST_REARMED},
        '{ACT_ADD_SEC, 4'd3,  16'hFFFF, 6'd0,  1'b1, ST_ADDED},
        '{ACT_ADD_SEC, 4'd4,  16'h0000, 6'd0,  1'b1, ST_ADDED},
        '{ACT_ADD_MIN, 4'd8,  16'd2,    6'd0,  1'b1, ST_ADDED},
        '{ACT_ADD_SEC, 4'd9,  16'd2,    6'd0,  1'b1, ST_ADDED},
        '{ACT_TICK,    4'd0,  16'h0000, 6'd0,  1'b0, ST_TICK},
        '{ACT_TICK,    4'd0,  16'h0000, 6'd59, 1'b0, ST_TICK},
        '{ACT_TICK,    4'd0,  16'h0000, 6'd63, 1'b0, ST_TICK},
        '{ACT_TICK,    4'd0,  16'h0000, 6'd63, 1'b0, ST_TICK},
        '{ACT_RSVD_5,  4'd1,  16'h0001, 6'd1,  1'b0, ST_TICK},
        '{ACT_RSVD_6,  4'd2,  16'h0002, 6'd2,  1'b0, ST_TICK},
        '{ACT_RSVD_7,  4'd3,  16'h0003, 6'd3,  1'b0, ST_TICK},
        '{ACT_QUERY,   4'd0,  16'h0000, 6'd0,  1'b1, ST_ARMED},
        '{ACT_REMOVE,  4'd0,  16'h0000, 6'd0,  1'b1, ST_REMOVED},
        '{ACT_REMOVE,  4'd0,  16'h0000, 6'd0,  1'b1, ST_NOTARMED},
        '{ACT_ADD_MIN, 4'd15, 16'hFFFF, 6'd0,  1'b1, ST_REARMED},
        '{ACT_TICK,    4'd0,  16'h0000, 6'd0,  1'b0, ST_TICK}
    };

    periodic_timer_slot_bank_top #(
        .NUM_SLOTS   (NUM_SLOTS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) i_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #15000000;
        $display("Some tests failed");
        $finish;
    end

    function automatic timer_result_t plain_result(input status_t st);
        timer_result_t r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void advance_timer_bank(input logic [2:0] action, input logic [3:0] slot,
                                               input logic [15:0] period,
                                               input logic [5:0] minute);
        timer_result_t r;
        bit            kind;
        bit            minute_step;
        bit [15:0]     next_count;
        logic [NUM_SLOTS-1:0] fire_mask;
        step_results.delete();
        case (action)
            ACT_ADD_SEC, ACT_ADD_MIN: begin
                kind = (action == ACT_ADD_MIN) ? KIND_MIN : KIND_SEC;
                if (!bank_armed[slot]) begin
                    bank_armed[slot] = 1'b1;
                    bank_kind[slot] = kind;
                    bank_reload[slot] = period;
                    bank_count[slot] = period;
                    step_results.push_back(plain_result(ST_ADDED));
                end else if (bank_kind[slot] == kind) begin
                    bank_reload[slot] = period;
                    bank_count[slot] = period;
                    step_results.push_back(plain_result(ST_REARMED));
                end else begin
                    step_results.push_back(plain_result(ST_WRONGKIND));
                end
            end
            ACT_REMOVE: begin
                if (bank_armed[slot]) begin
                    bank_armed[slot] = 1'b0;
                    step_results.push_back(plain_result(ST_REMOVED));
                end else begin
                    step_results.push_back(plain_result(ST_NOTARMED));
                end
            end
            ACT_QUERY: begin
                step_results.push_back(plain_result(bank_armed[slot] ? ST_ARMED : ST_UNARMED));
            end
            ACT_TICK: begin
                minute_step = 1'b0;
                if (!minute_valid) begin
                    minute_valid = 1'b1;
                    prev_minute = minute;
                end else if (prev_minute != minute) begin
                    minute_step = 1'b1;
                    prev_minute = minute;
                end
                fire_mask = '0;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (bank_armed[i] && (bank_kind[i] == KIND_SEC || minute_step)) begin
                        next_count = bank_count[i] - 16'd1;
                        if (next_count == '0) begin
                            bank_count[i] = bank_reload[i];
                            fire_mask[i] = 1'b1;
                        end else begin
                            bank_count[i] = next_count;
                        end
                    end
                end
                if (fire_mask == '0) begin
                    step_results.push_back(plain_result(ST_TICK));
                end else begin
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (fire_mask[i]) begin
                            r = '0;
                            r.status = ST_TICK;
                            r.fired = 1'b1;
                            r.fired_slot = 4'(i);
                            r.fired_kind = bank_kind[i];
                            r.last = ((fire_mask >> (i + 1)) == '0);
                            step_results.push_back(r);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    task automatic send_item(input logic [2:0] action, input logic [3:0] slot,
                             input logic [15:0] period, input logic [5:0] minute,
                             input bit pinned, input status_t pin_status);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= action;
        s_slot <= slot;
        s_period <= period;
        s_minute_now <= minute;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        advance_timer_bank(action, slot, period, minute);
        if (pinned) begin
            due_results.push_back(plain_result(pin_status));
        end else begin
            foreach (step_results[k]) due_results.push_back(step_results[k]);
        end
    endtask

    task automatic send_random_items(input int count);
        int         sent;
        int         roll;
        logic [2:0] action;
        logic [15:0] period;
        logic [5:0] minute;
        sent = 0;
        while (sent < count) begin
            roll = $urandom_range(99);
            if (roll < 22) action = ACT_ADD_SEC;
            else if (roll < 36) action = ACT_ADD_MIN;
            else if (roll < 46) action = ACT_REMOVE;
            else if (roll < 56) action = ACT_QUERY;
            else if (roll < 95) action = ACT_TICK;
            else action = 3'($urandom_range(ACT_RSVD_5, ACT_RSVD_7));
            roll = $urandom_range(99);
            if (roll < 70) period = 16'($urandom_range(1, 4));
            else if (roll < 90) period = 16'($urandom_range(5, 40));
            else period = 16'($urandom());
            if (action == ACT_TICK) begin
                if ($urandom_range(99) < 40) cur_minute = 6'($urandom_range(63));
                minute = cur_minute;
            end else begin
                minute = 6'($urandom_range(63));
            end
            send_item(action, 4'($urandom_range(15)), period, minute, 1'b0, ST_TICK);
            if (action <= ACT_QUERY) sent++;
        end
    endtask

    function automatic void compare_field(input string name, input logic [3:0] want,
                                          input logic [3:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                $error("unexpected result item: status %0d, slot %0d", m_status, m_fired_slot);
                error_count++;
            end else begin
                head_result = due_results.pop_front();
                compare_field("status", head_result.status, m_status);
                compare_field("fired", head_result.fired, m_fired);
                compare_field("fired_slot", head_result.fired_slot, m_fired_slot);
                compare_field("fired_kind", head_result.fired_kind, m_fired_kind);
                compare_field("last", head_result.last, m_last);
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        cur_minute = '0;
        send_idle_pct = 19;
        recv_idle_pct = 82;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].action, directed_rows[r].slot, directed_rows[r].period,
                      directed_rows[r].minute, directed_rows[r].pinned,
                      directed_rows[r].pin_status);
        end
        send_random_items(RANDOM_PER_PHASE);

        send_idle_pct = 82;
        recv_idle_pct = 19;
        send_random_items(RANDOM_PER_PHASE);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // arm every slot to fire on each tick, then hold the output while ticks pile up
        for (int s = 0; s < NUM_SLOTS; s++) begin
            send_item(ACT_REMOVE, 4'(s), 16'($urandom()), 6'($urandom_range(63)), 1'b0, ST_TICK);
            send_item(ACT_ADD_SEC, 4'(s), 16'd1, 6'($urandom_range(63)), 1'b0, ST_TICK);
        end
        hold_request = 1'b1;
        repeat (20) send_item(ACT_TICK, 4'($urandom_range(15)), 16'($urandom()), cur_minute,
                              1'b0, ST_TICK);
        send_random_items(RANDOM_PER_PHASE);

        s_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
